### hdl/cfde_pkg.sv
package cfde_pkg;

  localparam int COMP_BITS  = 32;
  localparam int FRAC_BITS  = 30;
  localparam int COORD_BITS = FRAC_BITS + 2;
  // one integer quotient bit, then one bit per fraction place
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int REM_BITS   = COMP_BITS + 1;

  typedef logic [2:0] face_t;

  localparam face_t FACE_ZERO = 3'd0;
  localparam face_t FACE_PX   = 3'd1;
  localparam face_t FACE_PY   = 3'd2;
  localparam face_t FACE_PZ   = 3'd3;
  localparam face_t FACE_NZ   = 3'd4;
  localparam face_t FACE_NY   = 3'd5;
  localparam face_t FACE_NX   = 3'd6;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
  } in_word_t;

  typedef struct packed {
    face_t                        face_number;
    logic signed [COORD_BITS-1:0] face_u;
    logic signed [COORD_BITS-1:0] face_v;
  } out_word_t;

  // classified word: face, magnitudes to divide and result signs
  typedef struct packed {
    face_t                face;
    logic [COMP_BITS-1:0] num_u;
    logic [COMP_BITS-1:0] num_v;
    logic [COMP_BITS-1:0] den;
    logic                 neg_u;
    logic                 neg_v;
  } cls_word_t;

endpackage

### hdl/cfde_front.sv
module cfde_front
  import cfde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      cls_valid,
  input  logic      cls_ready,
  output cls_word_t cls_word
);

  logic                 nx, ny, nz;
  logic [COMP_BITS-1:0] ax, ay, az;
  cls_word_t            cls_nxt;
  cls_word_t            cls_r;
  logic                 cls_valid_r;

  always_comb begin
    nx = in_word.dir_x[COMP_BITS-1];
    ny = in_word.dir_y[COMP_BITS-1];
    nz = in_word.dir_z[COMP_BITS-1];
    // most negative value maps to magnitude 2^(COMP_BITS-1)
    ax = nx ? (~in_word.dir_x + 1'b1) : in_word.dir_x;
    ay = ny ? (~in_word.dir_y + 1'b1) : in_word.dir_y;
    az = nz ? (~in_word.dir_z + 1'b1) : in_word.dir_z;
  end

  always_comb begin
    cls_nxt = '0;
    priority if (ax == '0 && ay == '0 && az == '0) begin
      // 0/1 divides to zero
      cls_nxt.face = FACE_ZERO;
      cls_nxt.den  = COMP_BITS'(1);
    end else if (az >= ax && az >= ay) begin
      cls_nxt.face  = nz ? FACE_NZ : FACE_PZ;
      cls_nxt.num_u = ax;
      cls_nxt.neg_u = nx;
      cls_nxt.num_v = ay;
      cls_nxt.neg_v = ny ^ nz;
      cls_nxt.den   = az;
    end else if (ay >= ax) begin
      cls_nxt.face  = ny ? FACE_NY : FACE_PY;
      cls_nxt.num_u = az;
      cls_nxt.neg_u = nz;
      cls_nxt.num_v = ax;
      cls_nxt.neg_v = nx ^ ny;
      cls_nxt.den   = ay;
    end else begin
      cls_nxt.face  = nx ? FACE_NX : FACE_PX;
      cls_nxt.num_u = ay;
      cls_nxt.neg_u = ny;
      cls_nxt.num_v = az;
      cls_nxt.neg_v = nz ^ nx;
      cls_nxt.den   = ax;
    end
  end

  assign in_ready  = !cls_valid_r || cls_ready;
  assign cls_valid = cls_valid_r;
  assign cls_word  = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid_r <= 1'b0;
    end else if (in_ready) begin
      cls_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

### hdl/cfde_fifo.sv
module cfde_fifo
  import cfde_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cls_word_t wr_word,
  output logic      rd_valid,
  input  logic      rd_ready,
  output cls_word_t rd_word
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cls_word_t             mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   count_r;
  logic                  push, pop;

  assign wr_ready = (count_r != CNT_BITS'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_word  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      // pointers wrap at the last entry, any depth
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

### hdl/cfde_back.sv
module cfde_back
  import cfde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cls_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  typedef struct packed {
    face_t                face;
    logic [COMP_BITS-1:0] den;
    logic [COMP_BITS-1:0] rem_u;
    logic [COMP_BITS-1:0] rem_v;
    logic [QUO_BITS-1:0]  q_u;
    logic [QUO_BITS-1:0]  q_v;
    logic                 neg_u;
    logic                 neg_v;
  } stage_t;

  stage_t             stg_r   [QUO_BITS];
  stage_t             stg_in  [QUO_BITS];
  stage_t             stg_nxt [QUO_BITS];
  logic [QUO_BITS-1:0] vld_r;
  logic               out_valid_r;
  out_word_t          out_r;
  logic               adv;
  stage_t             last;

  // whole pipe moves when the output register can take a word
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    stg_in[0]       = '0;
    stg_in[0].face  = in_word.face;
    stg_in[0].den   = in_word.den;
    stg_in[0].rem_u = in_word.num_u;
    stg_in[0].rem_v = in_word.num_v;
    stg_in[0].neg_u = in_word.neg_u;
    stg_in[0].neg_v = in_word.neg_v;
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [REM_BITS-1:0] t_u, t_v, d_u, d_v, den_x;
    logic                ge_u, ge_v;

    if (k > 0) begin : g_link
      assign stg_in[k] = stg_r[k-1];
    end

    always_comb begin
      den_x = {1'b0, stg_in[k].den};
      // integer bit uses the numerator as is, later bits shift first
      if (k == 0) begin
        t_u = {1'b0, stg_in[k].rem_u};
        t_v = {1'b0, stg_in[k].rem_v};
      end else begin
        t_u = {stg_in[k].rem_u, 1'b0};
        t_v = {stg_in[k].rem_v, 1'b0};
      end
      d_u  = t_u - den_x;
      d_v  = t_v - den_x;
      ge_u = (t_u >= den_x);
      ge_v = (t_v >= den_x);
      stg_nxt[k]       = stg_in[k];
      stg_nxt[k].rem_u = ge_u ? d_u[COMP_BITS-1:0] : t_u[COMP_BITS-1:0];
      stg_nxt[k].rem_v = ge_v ? d_v[COMP_BITS-1:0] : t_v[COMP_BITS-1:0];
      stg_nxt[k].q_u   = {stg_in[k].q_u[QUO_BITS-2:0], ge_u};
      stg_nxt[k].q_v   = {stg_in[k].q_v[QUO_BITS-2:0], ge_v};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign last = stg_r[QUO_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[QUO_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.face_number <= last.face;
      out_r.face_u <= last.neg_u ? -COORD_BITS'(last.q_u) : COORD_BITS'(last.q_u);
      out_r.face_v <= last.neg_v ? -COORD_BITS'(last.q_v) : COORD_BITS'(last.q_v);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### hdl/cube_face_direction_encode.sv
// Path: input word to result word through the classify register, the queue,
//   FRAC_BITS + 1 divide stages and the output register.
// Throughput: one word per cycle when the output does not stall; each divide stage
//   resolves one quotient bit for both face coordinates; depth sets the latency.
// Reset: rst_n synchronous, active low; clears all valid bits and queue pointers.
module cube_face_direction_encode
  import cfde_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // front -> queue
  logic      cls_valid, cls_ready;
  cls_word_t cls_word;
  // queue -> divide pipe
  logic      q_valid, q_ready;
  cls_word_t q_word;

  // Front: magnitudes, major axis pick (z over y over x on ties), signs.
  // A zero vector is sent as 0/1 so the divider yields zero coordinates.
  cfde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_word  (cls_word)
  );

  // Short queue decouples classify from the divide pipe stall.
  cfde_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_word  (cls_word),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_word  (q_word)
  );

  // Back: restoring divide, one bit per stage, sign applied at the output.
  cfde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_word   (q_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  // accepted word always lands in the classify register
  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> cls_valid)
    else $error("classify register did not load");

  // zero vector yields zero coordinates
  a_zero_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.face_number == FACE_ZERO |->
      out_word.face_u == '0 && out_word.face_v == '0)
    else $error("zero vector with nonzero coordinates");

  // face 7 is never produced
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.face_number <= FACE_NX)
    else $error("illegal face number");

  // queue never both refuses and sits empty
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !cls_ready |-> q_valid)
    else $error("queue full and empty at once");
`endif

endmodule

### sim/cube_face_direction_encode_test.sv
module cube_face_direction_encode_test;
  import cfde_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  cube_face_direction_encode dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  // Pipeline depth described at the top of the block, plus margin.
  localparam int DRAIN_CYCLES = FRAC_BITS + 20;

  out_word_t face_queue[$];   // projections waiting for their result word
  int        error_count;
  bit        hold_off;        // forces the receiver to stall for a long stretch

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // trunc(num * 2^FRAC_BITS / den), sign applied after, masked to coord width
  function automatic logic [COORD_BITS-1:0] face_ratio(
    input logic [COMP_BITS-1:0] num,
    input logic [COMP_BITS-1:0] den,
    input bit                   neg
  );
    logic [COMP_BITS+FRAC_BITS:0] q;
    q = ({{(FRAC_BITS+1){1'b0}}, num} << FRAC_BITS) / den;
    if (neg) q = -q;
    return q[COORD_BITS-1:0];
  endfunction

  // magnitude of a component; the most negative value maps to 2^(COMP_BITS-1)
  function automatic logic [COMP_BITS-1:0] comp_mag(input logic [COMP_BITS-1:0] c);
    return c[COMP_BITS-1] ? -c : c;
  endfunction

  function automatic out_word_t project_dir(input in_word_t d);
    out_word_t r;
    logic [COMP_BITS-1:0] ax, ay, az;
    bit nx, ny, nz;
    ax = comp_mag(d.dir_x);
    ay = comp_mag(d.dir_y);
    az = comp_mag(d.dir_z);
    nx = d.dir_x[COMP_BITS-1];
    ny = d.dir_y[COMP_BITS-1];
    nz = d.dir_z[COMP_BITS-1];
    if (ax == 0 && ay == 0 && az == 0) begin
      r.face_number = FACE_ZERO;
      r.face_u = '0;
      r.face_v = '0;
    end else if (az >= ax && az >= ay) begin
      // z wins every tie
      r.face_number = nz ? FACE_NZ : FACE_PZ;
      r.face_u = face_ratio(ax, az, nx);
      r.face_v = face_ratio(ay, az, ny != nz);
    end else if (ay >= ax) begin
      // y wins a tie with x
      r.face_number = ny ? FACE_NY : FACE_PY;
      r.face_u = face_ratio(az, ay, nz);
      r.face_v = face_ratio(ax, ay, nx != ny);
    end else begin
      r.face_number = nx ? FACE_NX : FACE_PX;
      r.face_u = face_ratio(ay, ax, ny);
      r.face_v = face_ratio(az, ax, nz != nx);
    end
    return r;
  endfunction

  // Send one direction word: offer at the falling edge, hold until accepted.
  task automatic send_dir(input logic [COMP_BITS-1:0] x, input logic [COMP_BITS-1:0] y,
                          input logic [COMP_BITS-1:0] z);
    in_word_t w;
    w.dir_x = x;
    w.dir_y = y;
    w.dir_z = z;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    face_queue = {face_queue, project_dir(w)};
    // lowered at the next falling edge, so back-to-back sends drop it between words
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Back-to-back sends drop valid between words; the burst sender instead keeps
  // valid high across accepted words.
  task automatic send_burst(input int count);
    in_word_t w;
    for (int i = 0; i < count; i++) begin
      w = rand_dir();
      in_valid <= 1'b1;
      in_word  <= w;
      do @(posedge clk); while (!in_ready);
      face_queue = {face_queue, project_dir(w)};
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  function automatic logic [COMP_BITS-1:0] rand_comp();
    logic [COMP_BITS-1:0] c;
    case ($urandom_range(0, 7))
      0: c = $urandom_range(0, 4) - 2;                  // tiny values and zero
      1: c = {1'b0, {(COMP_BITS-1){1'b1}}};              // largest positive
      2: c = {1'b1, {(COMP_BITS-1){1'b0}}};              // most negative
      3: c = $urandom_range(0, 1000) - 500;
      default: c = $urandom;
    endcase
    return c;
  endfunction

  function automatic in_word_t rand_dir();
    in_word_t w;
    w.dir_x = rand_comp();
    w.dir_y = rand_comp();
    w.dir_z = rand_comp();
    // force magnitude ties now and then
    case ($urandom_range(0, 5))
      0: w.dir_y = $urandom_range(0, 1) ? w.dir_x : -w.dir_x;
      1: w.dir_z = $urandom_range(0, 1) ? w.dir_y : -w.dir_y;
      2: begin
        w.dir_y = $urandom_range(0, 1) ? w.dir_x : -w.dir_x;
        w.dir_z = $urandom_range(0, 1) ? w.dir_x : -w.dir_x;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_empty();
    while (face_queue.size() != 0) @(negedge clk);
  endtask

  // Receiver: own stall pattern, overridden by the hold-off flag.
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off) out_ready <= 1'b0;
      else if ((phase % 64) < 20) out_ready <= 1'b1;   // stretch with no stalls
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker against the oldest waiting projection.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (face_queue.size() == 0) begin
        $display("%0t: result word with none expected: %h", $time, out_word);
        error_count++;
      end else begin
        exp_w = face_queue.pop_front();
        if (out_word.face_number !== exp_w.face_number) begin
          $display("%0t: face_number expected %0d actual %0d", $time,
                   exp_w.face_number, out_word.face_number);
          error_count++;
        end
        if (out_word.face_u !== exp_w.face_u) begin
          $display("%0t: face_u expected %h actual %h", $time, exp_w.face_u,
                   out_word.face_u);
          error_count++;
        end
        if (out_word.face_v !== exp_w.face_v) begin
          $display("%0t: face_v expected %h actual %h", $time, exp_w.face_v,
                   out_word.face_v);
          error_count++;
        end
      end
    end
  end

  // Extremes, zero vector, every face, ties and the most negative component.
  task automatic test_directed();
    logic [COMP_BITS-1:0] pmax, nmin;
    pmax = {1'b0, {(COMP_BITS-1){1'b1}}};
    nmin = {1'b1, {(COMP_BITS-1){1'b0}}};
    send_dir(0, 0, 0);
    send_dir(5, 1, -2);          // +x
    send_dir(-5, 1, 2);          // -x
    send_dir(1, 7, -3);          // +y
    send_dir(1, -7, 3);          // -y
    send_dir(-1, 2, 9);          // +z
    send_dir(1, -2, -9);         // -z
    send_dir(4, 4, 1);           // y beats x on a tie
    send_dir(4, -4, 4);          // z beats both
    send_dir(-3, 1, -3);         // z beats x
    send_dir(pmax, pmax, pmax);
    send_dir(nmin, 0, 0);
    send_dir(0, nmin, pmax);
    send_dir(pmax, 1, nmin);
    send_dir(nmin, nmin, nmin);
    send_dir(-pmax, pmax, -1);
    send_dir(3, 1, 2);           // inexact quotients
    send_dir(-7, 3, -5);
    send_dir(pmax, pmax - 1, -(pmax - 1));
    wait_empty();
  endtask

  // Random bursts with random gaps.
  task automatic test_random(input int total);
    int sent, n;
    sent = 0;
    while (sent < total) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      send_burst(n);
      sent += n;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  // Receiver holds off long enough that the pipeline fills and stalls input.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (FRAC_BITS * 3) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        @(negedge clk);
        send_burst(80);
      end
    join
    wait_empty();   // sender pauses until everything is back
  endtask

  initial begin
    error_count = 0;
    hold_off    = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(180);
    test_backpressure();
    test_random(190);
    wait_empty();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && face_queue.size() == 0)
      $display("** cube_face_direction_encode: PASSED **");
    else
      $display("** cube_face_direction_encode: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("** cube_face_direction_encode: FAILED **");
    $finish;
  end

endmodule
